[rtl/assert_macros.svh]
// assertion macros shared by the rtl files
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define QKB_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define QKB_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/qkb_pkg.sv]
// shared types and constants for the quadrature knob with button block
// no dependencies
package qkb_pkg;

  // configuration port
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic REG_LONG_PRESS_MS = 1'b0;  // register index, taken from paddr[2]
  localparam logic [31:0] LONG_PRESS_RESET = 32'd1000;

  // input command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CAPTURE = 1'b1;

  // button phase codes
  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_PRESSING = 2'd1;
  localparam logic [1:0] PHASE_LONG = 2'd2;

  // direction codes
  localparam logic signed [1:0] DIR_NONE = 2'sd0;
  localparam logic signed [1:0] DIR_CW = 2'sd1;
  localparam logic signed [1:0] DIR_CCW = -2'sd1;

  // detent thresholds on the widened step sum
  localparam logic signed [3:0] STEP_DETENT_POS = 4'sd4;
  localparam logic signed [3:0] STEP_DETENT_NEG = -4'sd4;
  localparam logic signed [2:0] STEP_ILLEGAL = 3'sb100;

  // x4 transition table indexed by {previous pair, current pair}
  localparam logic signed [1:0] TRANS_DELTA [0:15] = '{
    2'sd0, -2'sd1, 2'sd1, 2'sd0,
    2'sd1, 2'sd0, 2'sd0, -2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd1,
    2'sd0, 2'sd1, -2'sd1, 2'sd0
  };

  // one result request
  typedef struct packed {
    logic signed [1:0] direction;
    logic short_press;
    logic long_hold;
  } result_t;

endpackage

[rtl/quadrature_knob_with_button_core.sv]
// quadrature knob decoder (x4) with short and long button press detection
// depends on qkb_pkg and assert_macros.svh
//
// usage:
//   input channel: in_valid/in_ready with command, pin_a, pin_b, button_level
//   and now_ms. each accepted request yields exactly one result request on
//   out_valid/out_ready carrying direction, short_press and long_hold.
//   command 1 only captures the pin pair and returns an all-zero result.
//   the result is registered; while a result waits it goes to the skid register.
//   throughput: one request per cycle unless stalled; the whole update is one table
//   lookup, a 4-bit add and a 32-bit subtract and compare before the result register.
//   stall: a result register plus a one-entry skid register; one more input
//   is taken while a result waits, then in_ready drops until out_ready.
//   configuration: long_press_ms at byte address 0 over the apb-style port; the user
//   must write it only while idle (the block does not enforce it); pready is always high,
//   reads return the value. reset (rst, synchronous, active high): threshold 1000 ms,
//   pin pair and step count zero, button idle, press start zero, no result pending.
module quadrature_knob_with_button_core (
  input  logic clk,
  input  logic rst,
  // configuration port
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [qkb_pkg::ADDR_W-1:0] paddr,
  input  logic [qkb_pkg::DATA_W-1:0] pwdata,
  output logic [qkb_pkg::DATA_W-1:0] prdata,
  output logic pready,
  // input requests
  input  logic in_valid,
  output logic in_ready,
  input  logic command,
  input  logic pin_a,
  input  logic pin_b,
  input  logic button_level,
  input  logic [31:0] now_ms,
  // result requests
  output logic out_valid,
  input  logic out_ready,
  output logic signed [1:0] direction,
  output logic short_press,
  output logic long_hold
);
  import qkb_pkg::*;

  logic [31:0] long_press_ms;
  logic [1:0] previous_pins;
  logic signed [2:0] step_count;
  logic [1:0] button_phase;
  logic [31:0] press_start_ms;

  logic [1:0] previous_pins_next;
  logic signed [2:0] step_count_next;
  logic [1:0] button_phase_next;
  logic [31:0] press_start_ms_next;
  result_t result_next;

  result_t out_data;
  result_t skid_data;
  logic skid_valid;

  logic in_fire;
  logic out_fire;
  logic cfg_write;
  logic [1:0] pins;
  logic signed [1:0] delta;
  logic signed [3:0] step_sum;
  logic [31:0] held_ms;

  // configuration register
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_LONG_PRESS_MS) ? long_press_ms : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= LONG_PRESS_RESET;
    end else if (cfg_write && paddr[2] == REG_LONG_PRESS_MS) begin
      long_press_ms <= pwdata;
    end
  end

  // handshakes
  assign in_ready = !skid_valid;
  assign in_fire = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // step count update from the transition table
  assign pins = {pin_a, pin_b};
  assign delta = TRANS_DELTA[{previous_pins, pins}];
  assign step_sum = {step_count[2], step_count} + {{2{delta[1]}}, delta};
  assign held_ms = now_ms - press_start_ms;

  always_comb begin
    previous_pins_next = pins;
    step_count_next = step_count;
    button_phase_next = button_phase;
    press_start_ms_next = press_start_ms;
    result_next = '{direction: DIR_NONE, short_press: 1'b0, long_hold: 1'b0};

    if (command == CMD_SAMPLE) begin
      // detent detection
      if (step_sum >= STEP_DETENT_POS) begin
        result_next.direction = DIR_CW;
        step_count_next = '0;
      end else if (step_sum <= STEP_DETENT_NEG) begin
        result_next.direction = DIR_CCW;
        step_count_next = '0;
      end else begin
        step_count_next = step_sum[2:0];
      end

      // button machine, the unused code behaves as idle
      unique case (button_phase)
        PHASE_PRESSING: begin
          if (button_level) begin
            result_next.short_press = 1'b1;
            button_phase_next = PHASE_IDLE;
          end else if (held_ms >= long_press_ms) begin
            result_next.long_hold = 1'b1;
            button_phase_next = PHASE_LONG;
          end
        end
        PHASE_LONG: begin
          if (button_level) begin
            button_phase_next = PHASE_IDLE;
          end
        end
        default: begin
          if (!button_level) begin
            button_phase_next = PHASE_PRESSING;
            press_start_ms_next = now_ms;
          end else begin
            button_phase_next = PHASE_IDLE;
          end
        end
      endcase
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_pins <= '0;
      step_count <= '0;
      button_phase <= PHASE_IDLE;
      press_start_ms <= '0;
    end else if (in_fire) begin
      previous_pins <= previous_pins_next;
      step_count <= step_count_next;
      button_phase <= button_phase_next;
      press_start_ms <= press_start_ms_next;
    end
  end

  // result register and skid register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        out_data <= skid_data;
      end
    end else if (in_fire) begin
      if (out_valid && !out_ready) begin
        skid_data <= result_next;
      end else begin
        out_data <= result_next;
      end
    end
  end

  assign direction = out_data.direction;
  assign short_press = out_data.short_press;
  assign long_hold = out_data.long_hold;

  // checks
`include "assert_macros.svh"

  `QKB_ASSERT_NOW(a_skid_implies_out, clk, rst, skid_valid, out_valid)
  `QKB_ASSERT_NEXT(a_stall_fills_skid, clk, rst, in_fire && out_valid && !out_ready, skid_valid)
  `QKB_ASSERT_NEXT(a_skid_drains, clk, rst, skid_valid && out_ready, out_valid && !skid_valid)
  `QKB_ASSERT_NOW(a_step_in_range, clk, rst, 1'b1, step_count != STEP_ILLEGAL)

endmodule

[bench/quadrature_knob_with_button_core_tb.sv]
// testbench for quadrature_knob_with_button_core: directed table then random pin streams
// depends on qkb_pkg and the core; predicts results in-bench or uses typed ones, checks in order
`timescale 1ns / 100ps

module quadrature_knob_with_button_core_tb;
  import qkb_pkg::*;

  // one input request as the bench sees it
  typedef struct packed {
    logic command;
    logic pin_a;
    logic pin_b;
    logic button_level;
    logic [31:0] now_ms;
  } knob_reading_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // directed row: a request, or a threshold write (value is then the threshold)
  typedef struct packed {
    row_kind_t kind;
    logic command;
    logic pin_a;
    logic pin_b;
    logic button_level;
    logic [31:0] value;
    logic typed;
    result_t want;
  } directed_row_t;

  localparam logic [ADDR_W-1:0] THRESHOLD_ADDR = {REG_LONG_PRESS_MS, 2'b00};
  localparam int RUN_LIMIT_NS = 5_000_000;
  localparam int ITEMS_PER_PHASE = 210;

  localparam result_t NO_PULSE = '{DIR_NONE, 1'b0, 1'b0};
  localparam result_t CW_STEP = '{DIR_CW, 1'b0, 1'b0};
  localparam result_t CCW_STEP = '{DIR_CCW, 1'b0, 1'b0};
  localparam result_t SHORT_PULSE = '{DIR_NONE, 1'b1, 1'b0};
  localparam result_t LONG_PULSE = '{DIR_NONE, 1'b0, 1'b1};

  localparam int DIRECTED_ROWS = 27;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    // capture 00, then a full clockwise and a full counterclockwise detent
    '{ROW_REQ, CMD_CAPTURE, 1'b0, 1'b0, 1'b1, 32'd0, 1'b1, NO_PULSE},
    '{ROW_REQ, CMD_SAMPLE, 1'b1, 1'b0, 1'b1, 32'd1, 1'b0, NO_PULSE},
    '{ROW_REQ, CMD_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd2, 1'b0, NO_PULSE},
    '{ROW_REQ, CMD_SAMPLE, 1'b0, 1'b1, 1'b1, 32'd3, 1'b0, NO_PULSE},
    '{ROW_REQ, CMD_SAMPLE, 1'b0, 1'b0, 1'b1, 32'd4, 1'b1, CW_STEP},
    '{ROW_REQ, CMD_SAMPLE, 1'b0, 1'b1, 1'b1, 32'd5, 1'b0, NO_PULSE},
    '{ROW_REQ, CMD_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd6, 1'b0, NO_PULSE},
    '{ROW_REQ, CMD_SAMPLE, 1'b1, 1'b0, 1'b1, 32'd7, 1'b0, NO_PULSE},
    '{ROW_REQ, CMD_SAMPLE, 1'b0, 1'b0, 1'b1, 32'd8, 1'b1, CCW_STEP},
    // both bits changing counts nothing
    '{ROW_REQ, CMD_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd9, 1'b1, NO_PULSE},
    '{ROW_REQ, CMD_SAMPLE, 1'b0, 1'b0, 1'b1, 32'd10, 1'b1, NO_PULSE},
    // short press
    '{ROW_REQ, CMD_SAMPLE, 1'b0, 1'b0, 1'b0, 32'd100, 1'b0, NO_PULSE},
    '{ROW_REQ, CMD_SAMPLE, 1'b0, 1'b0, 1'b1, 32'd600, 1'b1, SHORT_PULSE},
    // long press across the time wrap, with a capture in the middle
    '{ROW_REQ, CMD_SAMPLE, 1'b0, 1'b0, 1'b0, 32'hFFFF_FF00, 1'b0, NO_PULSE},
    '{ROW_REQ, CMD_SAMPLE, 1'b0, 1'b0, 1'b0, 32'h0000_02E7, 1'b0, NO_PULSE},
    '{ROW_REQ, CMD_CAPTURE, 1'b1, 1'b1, 1'b1, 32'h0000_02E8, 1'b1, NO_PULSE},
    '{ROW_REQ, CMD_SAMPLE, 1'b1, 1'b1, 1'b0, 32'h0000_02E8, 1'b1, LONG_PULSE},
    '{ROW_REQ, CMD_SAMPLE, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, NO_PULSE},
    '{ROW_REQ, CMD_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0, NO_PULSE},
    // zero threshold: nothing on the press sample, long press on the next
    '{ROW_CFG, CMD_SAMPLE, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, NO_PULSE},
    '{ROW_REQ, CMD_SAMPLE, 1'b1, 1'b1, 1'b0, 32'h1234_5678, 1'b0, NO_PULSE},
    '{ROW_REQ, CMD_SAMPLE, 1'b1, 1'b1, 1'b0, 32'h1234_5678, 1'b0, NO_PULSE},
    '{ROW_REQ, CMD_SAMPLE, 1'b1, 1'b1, 1'b1, 32'h1234_5679, 1'b0, NO_PULSE},
    // largest threshold, reached only by a full wrap of held time
    '{ROW_CFG, CMD_SAMPLE, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, NO_PULSE},
    '{ROW_REQ, CMD_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd5, 1'b0, NO_PULSE},
    '{ROW_REQ, CMD_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd4, 1'b0, NO_PULSE},
    '{ROW_REQ, CMD_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd6, 1'b0, NO_PULSE}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = CMD_SAMPLE;
  logic pin_a = 1'b0;
  logic pin_b = 1'b0;
  logic button_level = 1'b1;
  logic [31:0] now_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [1:0] direction;
  logic short_press;
  logic long_hold;

  // predictor state
  logic [1:0] knob_prev_pins = 2'b00;
  int knob_steps = 0;
  logic [1:0] knob_phase = PHASE_IDLE;
  logic [31:0] knob_press_start = '0;
  logic [31:0] knob_threshold = LONG_PRESS_RESET;

  result_t results_due[$];
  int mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned ready_stall_pct = 0;

  quadrature_knob_with_button_core dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .pin_a(pin_a),
    .pin_b(pin_b),
    .button_level(button_level),
    .now_ms(now_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .direction(direction),
    .short_press(short_press),
    .long_hold(long_hold)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 40) begin
      $display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    end
    mismatch_count++;
  endtask

  // decoder and button machine; updates the predictor state and returns the result
  function automatic result_t decode_knob(input knob_reading_t r);
    result_t res;
    logic [1:0] pins;
    logic [1:0] old_pos;
    logic [1:0] new_pos;
    logic [1:0] ahead;
    logic [31:0] held;
    res = NO_PULSE;
    pins = {r.pin_a, r.pin_b};
    if (r.command == CMD_CAPTURE) begin
      knob_prev_pins = pins;
      return res;
    end
    // gray code to position on the wheel; one step back is clockwise
    old_pos = {knob_prev_pins[1], ^knob_prev_pins};
    new_pos = {pins[1], ^pins};
    ahead = old_pos - new_pos;
    if (ahead == 2'd1) begin
      knob_steps++;
    end else if (ahead == 2'd3) begin
      knob_steps--;
    end
    if (knob_steps >= 4) begin
      res.direction = DIR_CW;
      knob_steps = 0;
    end else if (knob_steps <= -4) begin
      res.direction = DIR_CCW;
      knob_steps = 0;
    end
    knob_prev_pins = pins;
    // button machine
    held = r.now_ms - knob_press_start;
    case (knob_phase)
      PHASE_PRESSING: begin
        if (r.button_level) begin
          res.short_press = 1'b1;
          knob_phase = PHASE_IDLE;
        end else if (held >= knob_threshold) begin
          res.long_hold = 1'b1;
          knob_phase = PHASE_LONG;
        end
      end
      PHASE_LONG: begin
        if (r.button_level) knob_phase = PHASE_IDLE;
      end
      default: begin
        if (!r.button_level) begin
          knob_phase = PHASE_PRESSING;
          knob_press_start = r.now_ms;
        end else begin
          knob_phase = PHASE_IDLE;
        end
      end
    endcase
    return res;
  endfunction

  // offer one request, hold it until taken, then record what it should produce
  task automatic send_reading(input knob_reading_t r, input bit typed, input result_t typed_want);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= r.command;
    pin_a <= r.pin_a;
    pin_b <= r.pin_b;
    button_level <= r.button_level;
    now_ms <= r.now_ms;
    do @(posedge clk); while (!in_ready);
    predicted = decode_knob(r);
    results_due.push_back(typed ? typed_want : predicted);
  endtask

  // threshold write, only once every outstanding result is back
  task automatic write_threshold(input logic [31:0] value);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= THRESHOLD_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    knob_threshold = value;
  endtask

  // receiver: random back-pressure and in-order comparison
  always @(posedge clk) begin : result_check
    result_t want;
    out_ready <= ($urandom_range(99) >= ready_stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with nothing outstanding", 1, 0);
      end else begin
        want = results_due.pop_front();
        if (direction !== want.direction) begin
          report_mismatch("direction", int'(direction), int'(want.direction));
        end
        if (short_press !== want.short_press) begin
          report_mismatch("short_press", int'(short_press), int'(want.short_press));
        end
        if (long_hold !== want.long_hold) begin
          report_mismatch("long_hold", int'(long_hold), int'(want.long_hold));
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned idle_by_phase [3];
    int unsigned stall_by_phase [3];
    int unsigned roll;
    knob_reading_t rd;
    logic [1:0] wheel_pos;
    logic [1:0] turn;
    logic held_level;
    logic [31:0] clock_ms;
    idle_by_phase = '{18, 73, 0};
    stall_by_phase = '{73, 18, 0};
    wheel_pos = 2'd0;
    turn = 2'd1;
    held_level = 1'b1;
    clock_ms = $urandom;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        write_threshold(DIRECTED[i].value);
      end else begin
        rd = '{DIRECTED[i].command, DIRECTED[i].pin_a, DIRECTED[i].pin_b,
               DIRECTED[i].button_level, DIRECTED[i].value};
        send_reading(rd, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    // random phases: turning knob with noise, captures and button presses
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: write_threshold($urandom_range(30));
        1: write_threshold($urandom_range(60));
        default: write_threshold($urandom_range(25, 1));
      endcase
      send_idle_pct = idle_by_phase[ph];
      ready_stall_pct = stall_by_phase[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        if (roll < 12) begin
          // capture or a random jump of the pins, possibly an illegal one
          rd.command = (roll < 4) ? CMD_CAPTURE : CMD_SAMPLE;
          {rd.pin_a, rd.pin_b} = 2'($urandom_range(3));
          wheel_pos = {rd.pin_a, rd.pin_a ^ rd.pin_b};
        end else begin
          // legal quadrature motion, mostly in one direction
          rd.command = CMD_SAMPLE;
          if ($urandom_range(9) == 0) turn = -turn;
          if ($urandom_range(7) != 0) wheel_pos = wheel_pos + turn;
          rd.pin_a = wheel_pos[1];
          rd.pin_b = wheel_pos[1] ^ wheel_pos[0];
        end
        if ($urandom_range(5) == 0) held_level = ~held_level;
        rd.button_level = held_level;
        roll = $urandom_range(99);
        if (roll == 0) begin
          clock_ms = $urandom;
        end else if (roll == 1) begin
          clock_ms = 32'hFFFF_FFF8;
        end else begin
          clock_ms = clock_ms + $urandom_range(8);
        end
        rd.now_ms = clock_ms;
        send_reading(rd, 1'b0, NO_PULSE);
      end
    end

    // drain
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL");
    $finish;
  end

endmodule
